// ----- design/crd_pkg.sv -----
// Shared types and constants of the camera ray direction block.
`default_nettype none
package crd_pkg;

   localparam int unsigned COORD_W   = 12;  // pixel coordinate field width
   localparam int unsigned SIZE_W    = 13;  // image size register width
   localparam int unsigned Q_W       = 16;  // Q1.15 word width
   localparam int unsigned CSR_IDX_W = 3;

   // Register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_COS_ROT_X    = 3'd2,
      REG_SIN_ROT_X    = 3'd3,
      REG_COS_ROT_Y    = 3'd4,
      REG_SIN_ROT_Y    = 3'd5,
      REG_COS_ROT_Z    = 3'd6,
      REG_SIN_ROT_Z    = 3'd7
   } reg_index_type;

   // Cosine and sine of one rotation angle, Q1.15
   typedef struct packed {
      logic signed [Q_W-1:0] cos_v;
      logic signed [Q_W-1:0] sin_v;
   } coef_type;

endpackage
`default_nettype wire

// ----- design/crd_req_if.sv -----
// Request channel: one pixel coordinate pair per beat.
`default_nettype none
interface crd_req_if;
   logic                          valid;
   logic                          ready;
   logic [crd_pkg::COORD_W-1:0]   pixel_x;
   logic [crd_pkg::COORD_W-1:0]   pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

// ----- design/crd_rsp_if.sv -----
// Response channel: one Q1.15 ray direction per beat.
`default_nettype none
interface crd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [crd_pkg::Q_W-1:0] dir_x;
   logic signed [crd_pkg::Q_W-1:0] dir_y;
   logic signed [crd_pkg::Q_W-1:0] dir_z;
   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface
`default_nettype wire

// ----- design/crd_sqrt.sv -----
// Pipelined integer square root of rad * 2^26, one root bit per stage.
`default_nettype none
module crd_sqrt #(
   parameter int unsigned SIDE_W = 42
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [29:0]       in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [27:0]            out_root,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int unsigned K = 28;

   logic              v_ff    [K];
   logic [31:0]       rem_ff  [K];
   logic [27:0]       root_ff [K];
   logic [29:0]       rad_ff  [K];
   logic [SIDE_W-1:0] side_ff [K];

   for (genvar k = 0; k < K; k++) begin : g_stage
      localparam int unsigned P = 2 * (K - 1 - k);
      logic              v_prev;
      logic [31:0]       rem_prev;
      logic [27:0]       root_prev;
      logic [29:0]       rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [55:0]       n_full;
      logic [31:0]       rem_sh;
      logic [31:0]       trial;
      logic [31:0]       rem_in;
      logic [27:0]       root_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // bring down the next bit pair and try the new root bit
      always_comb begin
         n_full = {rad_prev, 26'd0};
         rem_sh = {rem_prev[29:0], n_full[P+1 -: 2]};
         trial  = {2'b00, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[26:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[26:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[K-1];
   assign out_root  = root_ff[K-1];
   assign out_side  = side_ff[K-1];
endmodule
`default_nettype wire

// ----- design/crd_div.sv -----
// Three-lane pipelined restoring divider with a shared divisor, one quotient bit a stage.
`default_nettype none
module crd_div #(
   parameter int unsigned SIDE_W = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [2:0][42:0]  in_num,
   input  wire logic [27:0]       in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [2:0][17:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int unsigned J = 18;

   logic              v_ff    [J];
   logic [2:0][27:0]  rem_ff  [J];
   logic [2:0][17:0]  low_ff  [J];
   logic [2:0][17:0]  quo_ff  [J];
   logic [27:0]       den_ff  [J];
   logic [SIDE_W-1:0] side_ff [J];

   for (genvar j = 0; j < J; j++) begin : g_stage
      logic              v_prev;
      logic [2:0][27:0]  rem_prev;
      logic [2:0][17:0]  low_prev;
      logic [2:0][17:0]  quo_prev;
      logic [27:0]       den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [2:0][27:0]  rem_in;
      logic [2:0][17:0]  quo_in;

      if (j == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               rem_prev[l] = {3'b000, in_num[l][42:18]};
               low_prev[l] = in_num[l][17:0];
            end
         end
         assign v_prev    = in_valid;
         assign quo_prev  = '0;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign low_prev  = low_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // shift in the next dividend bit and subtract where it fits
      always_comb begin
         logic [28:0] rem2;
         for (int l = 0; l < 3; l++) begin
            rem2 = {rem_prev[l], low_prev[l][J-1-j]};
            if (rem2 >= {1'b0, den_prev}) begin
               rem_in[l] = 28'(rem2 - {1'b0, den_prev});
               quo_in[l] = {quo_prev[l][16:0], 1'b1};
            end else begin
               rem_in[l] = rem2[27:0];
               quo_in[l] = {quo_prev[l][16:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            low_ff[j]  <= low_prev;
            quo_ff[j]  <= quo_in;
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[J-1];
   assign out_quo   = quo_ff[J-1];
   assign out_side  = side_ff[J-1];
endmodule
`default_nettype wire

// ----- design/crd_rot.sv -----
// One plane rotation in two stages: products, then sum with rounding and saturation.
`default_nettype none
module crd_rot (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic signed [crd_pkg::Q_W-1:0] in_a,
   input  wire logic signed [crd_pkg::Q_W-1:0] in_b,
   input  wire logic signed [crd_pkg::Q_W-1:0] in_p,
   input  wire crd_pkg::coef_type              coef,
   output logic                                out_valid,
   output logic signed [crd_pkg::Q_W-1:0]      out_a,
   output logic signed [crd_pkg::Q_W-1:0]      out_b,
   output logic signed [crd_pkg::Q_W-1:0]      out_p
);
   logic                            v1_ff, v2_ff;
   logic signed [31:0]              ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [crd_pkg::Q_W-1:0]  p1_ff;
   logic signed [crd_pkg::Q_W-1:0]  a2_ff, b2_ff, p2_ff;
   logic signed [crd_pkg::Q_W-1:0]  a2_in, b2_in;

   // round half up by 2^15 and clamp to Q1.15
   function automatic logic signed [15:0] round_sat(input logic signed [32:0] s);
      logic signed [33:0] t;
      logic signed [33:0] sh;
      t  = 34'(s) + 34'sd16384;
      sh = t >>> 15;
      if (sh > 34'sd32767) begin
         return 16'sh7fff;
      end else if (sh < -34'sd32768) begin
         return 16'sh8000;
      end else begin
         return sh[15:0];
      end
   endfunction

   always_comb begin
      a2_in = round_sat(33'(ac_ff) - 33'(bs_ff));
      b2_in = round_sat(33'(as_ff) + 33'(bc_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // register the four products, then the combined pair
   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff <= 32'(in_a) * 32'(coef.cos_v);
         bs_ff <= 32'(in_b) * 32'(coef.sin_v);
         as_ff <= 32'(in_a) * 32'(coef.sin_v);
         bc_ff <= 32'(in_b) * 32'(coef.cos_v);
         p1_ff <= in_p;
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         p2_ff <= p1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_a     = a2_ff;
   assign out_b     = b2_ff;
   assign out_p     = p2_ff;
endmodule
`default_nettype wire

// ----- design/camera_ray_direction.sv -----
// Camera ray direction: pixel to rotated unit ray direction, fully pipelined.
// Usage:
//   req_bus carries one pixel (pixel_x, pixel_y) per beat; rsp_bus returns the
//   Q1.15 unit direction (dir_x, dir_y, dir_z) of that pixel's primary ray, in order.
//   The csr_ port writes image size and the rotation sines and cosines; write it
//   only while no beat is in flight.
// Throughput: one beat per clock while rsp_bus.ready does not hold the pipeline.
// Pipeline, from request beat to response valid: 3 vector and
//   square stages, 28 square root stages (one root bit each), 1 numerator stage,
//   18 divider stages (one quotient bit each), 1 saturation stage and three
//   rotations of 2 stages each.
// Stall: when a response waits and rsp_bus.ready is low, the whole pipeline
//   holds and req_bus.ready drops in the same cycle; nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits and loads the register
//   defaults (640 x 480, identity rotation).
`default_nettype none
module camera_ray_direction (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   crd_req_if.sink                                   req_bus,
   crd_rsp_if.source                                 rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [crd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [crd_pkg::Q_W-1:0]              csr_wdata
);
   localparam int unsigned SQ_SIDE_W = 42;

   // configuration registers
   logic [crd_pkg::SIZE_W-1:0] width_ff, height_ff;
   crd_pkg::coef_type          rot_x_ff, rot_y_ff, rot_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         rot_x_ff  <= '{cos_v: 16'sh7fff, sin_v: 16'sh0000};
         rot_y_ff  <= '{cos_v: 16'sh7fff, sin_v: 16'sh0000};
         rot_z_ff  <= '{cos_v: 16'sh7fff, sin_v: 16'sh0000};
      end else if (csr_we) begin
         unique case (crd_pkg::reg_index_type'(csr_index))
            crd_pkg::REG_IMAGE_WIDTH:  width_ff       <= csr_wdata[12:0];
            crd_pkg::REG_IMAGE_HEIGHT: height_ff      <= csr_wdata[12:0];
            crd_pkg::REG_COS_ROT_X:    rot_x_ff.cos_v <= csr_wdata;
            crd_pkg::REG_SIN_ROT_X:    rot_x_ff.sin_v <= csr_wdata;
            crd_pkg::REG_COS_ROT_Y:    rot_y_ff.cos_v <= csr_wdata;
            crd_pkg::REG_SIN_ROT_Y:    rot_y_ff.sin_v <= csr_wdata;
            crd_pkg::REG_COS_ROT_Z:    rot_z_ff.cos_v <= csr_wdata;
            crd_pkg::REG_SIN_ROT_Z:    rot_z_ff.sin_v <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: hold everything while a response waits
   logic en;
   logic out_valid;
   assign en            = !out_valid || rsp_bus.ready;
   assign req_bus.ready = en;

   // stage 1: doubled camera vector
   logic               v1_ff;
   logic signed [13:0] vx_ff, vy_ff;
   logic [13:0]        vz_ff;
   logic signed [14:0] vx_full, vy_full;

   always_comb begin
      vx_full = $signed({2'b00, req_bus.pixel_x, 1'b0}) - $signed({2'b00, width_ff});
      vy_full = $signed({2'b00, req_bus.pixel_y, 1'b0}) - $signed({2'b00, height_ff});
   end

   // stage 2: squares and magnitudes
   logic               v2_ff;
   logic [27:0]        sqx_ff, sqy_ff, sqz_ff;
   logic [12:0]        magx_ff, magy_ff;
   logic [13:0]        magz_ff;
   logic               sgnx_ff, sgny_ff;
   logic signed [27:0] sqx_in, sqy_in;
   logic [13:0]        absx_in, absy_in;

   always_comb begin
      sqx_in  = 28'(vx_ff) * 28'(vx_ff);
      sqy_in  = 28'(vy_ff) * 28'(vy_ff);
      absx_in = vx_ff[13] ? 14'(-vx_ff) : vx_ff;
      absy_in = vy_ff[13] ? 14'(-vy_ff) : vy_ff;
   end

   // stage 3: squared length
   logic        v3_ff;
   logic [29:0] sum_ff;
   logic [SQ_SIDE_W-1:0] side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff    <= vx_full[13:0];
         vy_ff    <= vy_full[13:0];
         vz_ff    <= {height_ff, 1'b0};
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         sqz_ff   <= {14'd0, vz_ff} * {14'd0, vz_ff};
         magx_ff  <= absx_in[12:0];
         magy_ff  <= absy_in[12:0];
         magz_ff  <= vz_ff;
         sgnx_ff  <= vx_ff[13];
         sgny_ff  <= vy_ff[13];
         sum_ff   <= {2'b00, sqx_ff} + {2'b00, sqy_ff} + {2'b00, sqz_ff};
         side3_ff <= {sgnx_ff, sgny_ff, magx_ff, magy_ff, magz_ff};
      end
   end

   // square root of the length, scaled by 2^13
   logic                 sq_valid;
   logic [27:0]          sq_root;
   logic [SQ_SIDE_W-1:0] sq_side;

   crd_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (sum_ff),
      .in_side   (side3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage 4: rounded numerators over the root
   logic             v4_ff;
   logic [2:0][42:0] num_ff;
   logic [27:0]      den_ff;
   logic [2:0]       flags_ff;   // zero vector, sign x, sign y

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= {2'b00, sq_side[39:27], 28'd0} + {16'd0, sq_root[27:1]};
         num_ff[1] <= {2'b00, sq_side[26:14], 28'd0} + {16'd0, sq_root[27:1]};
         num_ff[2] <= {1'b0, sq_side[13:0], 28'd0} + {16'd0, sq_root[27:1]};
         den_ff    <= sq_root;
         flags_ff  <= {sq_root == 28'd0, sq_side[41], sq_side[40]};
      end
   end

   logic             dv_valid;
   logic [2:0][17:0] dv_quo;
   logic [2:0]       dv_flags;

   crd_div #(.SIDE_W(3)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (flags_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_flags)
   );

   // stage 5: apply sign and clamp to Q1.15
   function automatic logic signed [15:0] signed_sat(input logic [17:0] q, input logic neg);
      if (!neg) begin
         return (q > 18'd32767) ? 16'sh7fff : q[15:0];
      end else begin
         return (q >= 18'd32768) ? 16'sh8000 : 16'(-q[15:0]);
      end
   endfunction

   logic               v5_ff;
   logic signed [15:0] ux_ff, uy_ff, uz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff <= dv_flags[2] ? 16'sd0 : signed_sat(dv_quo[0], dv_flags[1]);
         uy_ff <= dv_flags[2] ? 16'sd0 : signed_sat(dv_quo[1], dv_flags[0]);
         uz_ff <= dv_flags[2] ? 16'sd0 : signed_sat(dv_quo[2], 1'b0);
      end
   end

   // rotate about X (y,z), then Y (z,x), then Z (x,y)
   logic               rx_valid, ry_valid;
   logic signed [15:0] rx_y, rx_z, rx_x;
   logic signed [15:0] ry_z, ry_x, ry_y;

   crd_rot u_rot_x (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (v5_ff), .in_a (uy_ff), .in_b (uz_ff), .in_p (ux_ff), .coef (rot_x_ff),
      .out_valid (rx_valid), .out_a (rx_y), .out_b (rx_z), .out_p (rx_x)
   );

   crd_rot u_rot_y (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (rx_valid), .in_a (rx_z), .in_b (rx_x), .in_p (rx_y), .coef (rot_y_ff),
      .out_valid (ry_valid), .out_a (ry_z), .out_b (ry_x), .out_p (ry_y)
   );

   crd_rot u_rot_z (
      .clock (clock), .reset (reset), .en (en),
      .in_valid (ry_valid), .in_a (ry_x), .in_b (ry_y), .in_p (ry_z), .coef (rot_z_ff),
      .out_valid (out_valid), .out_a (rsp_bus.dir_x), .out_b (rsp_bus.dir_y),
      .out_p (rsp_bus.dir_z)
   );

   assign rsp_bus.valid = out_valid;

   // a held pipeline keeps its interior beats in place
   a_stall_holds_sqrt: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(sq_valid) && $stable(sq_root))
      else $error("square root stage moved during stall");

   // a zero-length vector leaves a zero unit vector
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (en && dv_valid && dv_flags[2]) |=> (ux_ff == 16'sd0 && uy_ff == 16'sd0 && uz_ff == 16'sd0))
      else $error("zero vector not cleared");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid && !v5_ff && !v4_ff)
      else $error("valid beat survived reset");

endmodule
`default_nettype wire
